>>> design/periodic_task_tick_scheduler_top_defines.svh
// assertion macros shared by the scheduler modules
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define PSCHED_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PSCHED_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/psched_pkg.sv
package psched_pkg;

    localparam int NUM_IDS  = 16;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam int DEF_MAX_TASKS   = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOAD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period;
        logic                has_action;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     fired_id;
        logic                last;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic walk_init;
        logic walk_step;
        logic load_exec;
        logic unld_absent;
        logic find_step;
        logic shift_step;
        logic unld_finish;
        logic flush;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             list_empty;
        logic             present_hit;
        logic             walk_last;
        logic             walk_stall;
        logic             find_match;
        logic             shift_more;
        logic             out_free;
    } dp_sts_t;

endpackage

>>> design/psched_dp.sv
`include "periodic_task_tick_scheduler_top_defines.svh"

module psched_dp import psched_pkg::*; #(
    parameter int MAX_TASKS   = DEF_MAX_TASKS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    input  logic      m_ready,
    output logic      m_valid,
    output out_word_t m_data
);

    localparam int CAP   = (MAX_TASKS < NUM_IDS) ? MAX_TASKS : NUM_IDS;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int LEN_W = $clog2(CAP + 1);
    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

    in_word_t               item_reg;
    logic [ID_W-1:0]        order_reg [CAP];
    logic [LEN_W-1:0]       len_reg;
    logic [NUM_IDS-1:0]     present_reg;
    logic [PERIOD_W-1:0]    period_reg [NUM_IDS];
    logic [COUNT_WIDTH-1:0] count_reg [NUM_IDS];
    logic [NUM_IDS-1:0]     action_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   held_valid_reg;
    logic [STATUS_W-1:0]    held_status_reg;
    logic [ID_W-1:0]        held_id_reg;
    logic                   m_valid_reg;
    out_word_t              m_data_reg;

    logic [LEN_W-1:0]       next_pos;
    logic [IDX_W-1:0]       nxt_idx;
    logic [ID_W-1:0]        cur_id;
    logic [ID_W-1:0]        nxt_id;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   fire;
    logic                   fire_act;
    logic                   out_free;
    logic                   list_full;
    logic                   push_walk;
    logic                   push;

    assign next_pos  = LEN_W'(idx_reg) + LEN_W'(1);
    assign nxt_idx   = IDX_W'(next_pos);
    assign cur_id    = order_reg[idx_reg];
    assign nxt_id    = order_reg[nxt_idx];
    assign cnt_inc   = count_reg[cur_id] + COUNT_WIDTH'(1);
    assign fire      = CMP_W'(cnt_inc) >= CMP_W'(period_reg[cur_id]);
    assign fire_act  = fire && action_reg[cur_id];
    assign out_free  = !m_valid_reg || m_ready;
    assign list_full = (len_reg == CAP_LEN);
    // an earlier firing goes out once a later one is known
    assign push_walk = cmd.walk_step && fire_act && held_valid_reg;
    assign push      = push_walk || cmd.flush;

    always_comb begin
        sts.command     = item_reg.command;
        sts.list_empty  = (len_reg == '0);
        sts.present_hit = present_reg[item_reg.task_id];
        sts.walk_last   = (next_pos >= len_reg);
        sts.walk_stall  = fire_act && held_valid_reg && !out_free;
        sts.find_match  = (cur_id == item_reg.task_id);
        sts.shift_more  = (next_pos < len_reg);
        sts.out_free    = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            present_reg    <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.walk_init) begin
                held_valid_reg <= 1'b0;
            end
            if ((cmd.walk_step && fire_act) || cmd.load_exec || cmd.unld_absent
                    || cmd.unld_finish) begin
                held_valid_reg <= 1'b1;
            end
            if (cmd.load_exec && !present_reg[item_reg.task_id] && !list_full) begin
                len_reg                       <= len_reg + LEN_W'(1);
                present_reg[item_reg.task_id] <= 1'b1;
            end
            if (cmd.unld_finish) begin
                len_reg                       <= len_reg - LEN_W'(1);
                present_reg[item_reg.task_id] <= 1'b0;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.walk_init) begin
            idx_reg <= '0;
        end
        if (cmd.walk_step || cmd.find_step || cmd.shift_step) begin
            idx_reg <= nxt_idx;
        end
        if (cmd.walk_step) begin
            count_reg[cur_id] <= fire ? '0 : cnt_inc;
            if (fire_act) begin
                held_status_reg <= ST_FIRED;
                held_id_reg     <= cur_id;
            end
        end
        if (cmd.load_exec) begin
            held_id_reg <= item_reg.task_id;
            if (present_reg[item_reg.task_id]) begin
                held_status_reg <= ST_ALREADY;
            end else if (list_full) begin
                held_status_reg <= ST_FULL;
            end else begin
                held_status_reg                  <= ST_DONE;
                order_reg[len_reg[IDX_W-1:0]]    <= item_reg.task_id;
                period_reg[item_reg.task_id]     <= item_reg.period;
                count_reg[item_reg.task_id]      <= '0;
                action_reg[item_reg.task_id]     <= item_reg.has_action;
            end
        end
        if (cmd.unld_absent) begin
            held_status_reg <= ST_NOT_FOUND;
            held_id_reg     <= item_reg.task_id;
        end
        if (cmd.shift_step) begin
            order_reg[idx_reg] <= nxt_id;
        end
        if (cmd.unld_finish) begin
            held_status_reg <= ST_DONE;
            held_id_reg     <= item_reg.task_id;
        end
        if (push_walk) begin
            m_data_reg <= '{status: held_status_reg, fired_id: held_id_reg, last: 1'b0};
        end else if (cmd.flush) begin
            if (held_valid_reg) begin
                m_data_reg <= '{status: held_status_reg, fired_id: held_id_reg, last: 1'b1};
            end else begin
                m_data_reg <= '{status: ST_DONE, fired_id: '0, last: 1'b1};
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PSCHED_ASSERT_IMP(a_len_cap, aclk, aresetn, 1'b1, len_reg <= CAP_LEN,
        "list length above capacity")
    `PSCHED_ASSERT_IMP(a_present_len, aclk, aresetn, 1'b1,
        $countones(present_reg) == 32'(len_reg), "present flags disagree with list length")
    `PSCHED_ASSERT_IMP(a_push_free, aclk, aresetn, push && m_valid_reg, m_ready,
        "result register overwritten while occupied")

endmodule

>>> design/psched_ctrl.sv
`include "periodic_task_tick_scheduler_top_defines.svh"

module psched_ctrl import psched_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIND,
        S_SHIFT,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   accept;

    assign accept = s_valid && s_ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (sts.command)
                    CMD_TICK: begin
                        cmd.walk_init = 1'b1;
                        state_next    = sts.list_empty ? S_FLUSH : S_WALK;
                    end
                    CMD_LOAD: begin
                        cmd.load_exec = 1'b1;
                        state_next    = S_FLUSH;
                    end
                    CMD_UNLOAD: begin
                        if (sts.present_hit) begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_FIND;
                        end else begin
                            cmd.unld_absent = 1'b1;
                            state_next      = S_FLUSH;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                if (!sts.walk_stall) begin
                    cmd.walk_step = 1'b1;
                    if (sts.walk_last) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FIND: begin
                if (sts.find_match) begin
                    state_next = S_SHIFT;
                end else begin
                    cmd.find_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (sts.shift_more) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    cmd.unld_finish = 1'b1;
                    state_next      = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

    `PSCHED_ASSERT_IMP(a_walk_nonempty, aclk, aresetn, state_reg == S_WALK, !sts.list_empty,
        "walking an empty list")
    `PSCHED_ASSERT_IMP(a_find_present, aclk, aresetn, state_reg == S_FIND, sts.present_hit,
        "searching for an id that is not listed")

endmodule

>>> design/periodic_task_tick_scheduler_top.sv
// periodic task tick scheduler
// input channel s_valid/s_ready/s_data carries one command word: tick, load task
// or unload task. result channel m_valid/m_ready/m_data carries status words.
// load and unload give exactly one word; a tick gives one fire word per firing
// task in load order with last on the final one, or a single done word.
// an unload of a listed id steps through the whole list wherever the id sits,
// first searching up to it and then shifting the rest down. the order list
// and the per-task state are walked one entry a cycle by the datapath, unless
// a tick walk holds for a full output register. one command is in work at a
// time.
// a finished word waits in the output register; a new command is taken while
// it waits. if the receiver stalls in a tick with several firings the walk
// holds until the register frees, so no word is lost.
// reset (aresetn, synchronous, active low) empties the list; the per-task
// period and counter storage is left as it was and is rewritten on load.
// command code 3 is taken and dropped without any result word.

module periodic_task_tick_scheduler_top import psched_pkg::*; #(
    parameter int MAX_TASKS   = DEF_MAX_TASKS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    // command words
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    // status words
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    dp_cmd_t cmd;   // sequencing strobes for the datapath
    dp_sts_t sts;   // decode and walk status back to the controller

    // sequencer: accept, decode, walk, find, shift, emit
    psched_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // task list, per-task counters and the result register
    psched_dp #(
        .MAX_TASKS   (MAX_TASKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

// checks the periodic task tick scheduler against a cycle-free model of its list
module tb;
    import psched_pkg::*;

    // command code with no meaning, dropped by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    periodic_task_tick_scheduler_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns period
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // model of the task list, written on every accepted command word
    logic [ID_W-1:0]     lst_ids   [NUM_IDS];
    int                  lst_len = 0;
    logic                id_listed [NUM_IDS];
    logic [PERIOD_W-1:0] id_period [NUM_IDS];
    logic [15:0]         id_count  [NUM_IDS];
    logic                id_action [NUM_IDS];

    out_word_t status_words_due [$];
    int        mismatches  = 0;
    bit        calm        = 1'b0;  // no idling on either side when set
    int        hold_cycles = 0;     // long receiver hold, picked up by the receiver process
    int        stall_left  = 0;

    initial begin
        for (int k = 0; k < NUM_IDS; k++) id_listed[k] = 1'b0;
    end

    function automatic in_word_t make_word(logic [CMD_W-1:0] cmd, int id, int per, bit act);
        in_word_t w;
        w.command    = cmd;
        w.task_id    = id[ID_W-1:0];
        w.period     = per[PERIOD_W-1:0];
        w.has_action = act;
        return w;
    endfunction

    // apply one command to the list model and queue the status words it causes
    function automatic void advance_schedule(in_word_t w);
        logic [ID_W-1:0] fire_ids [NUM_IDS];
        int              fires;
        int              pos;
        logic [ID_W-1:0] t;
        logic [15:0]     cnt;
        fires = 0;
        case (w.command)
            CMD_TICK: begin
                for (int i = 0; i < lst_len; i++) begin
                    t   = lst_ids[i];
                    cnt = id_count[t] + 16'd1;
                    if (cnt >= id_period[t]) begin
                        cnt = '0;
                        if (id_action[t]) begin
                            fire_ids[fires] = t;
                            fires++;
                        end
                    end
                    id_count[t] = cnt;
                end
                if (fires == 0)
                    status_words_due.push_back('{ST_DONE, '0, 1'b1});
                for (int i = 0; i < fires; i++)
                    status_words_due.push_back('{ST_FIRED, fire_ids[i], i == fires - 1});
            end
            CMD_LOAD: begin
                if (id_listed[w.task_id]) begin
                    status_words_due.push_back('{ST_ALREADY, w.task_id, 1'b1});
                end else if (lst_len >= NUM_IDS) begin
                    status_words_due.push_back('{ST_FULL, w.task_id, 1'b1});
                end else begin
                    lst_ids[lst_len]     = w.task_id;
                    lst_len++;
                    id_listed[w.task_id] = 1'b1;
                    id_period[w.task_id] = w.period;
                    id_count[w.task_id]  = '0;
                    id_action[w.task_id] = w.has_action;
                    status_words_due.push_back('{ST_DONE, w.task_id, 1'b1});
                end
            end
            CMD_UNLOAD: begin
                if (!id_listed[w.task_id]) begin
                    status_words_due.push_back('{ST_NOT_FOUND, w.task_id, 1'b1});
                end else begin
                    pos = 0;
                    while (lst_ids[pos] != w.task_id) pos++;
                    // close the gap, order of the rest kept
                    for (int j = pos; j < lst_len - 1; j++) lst_ids[j] = lst_ids[j + 1];
                    lst_len--;
                    id_listed[w.task_id] = 1'b0;
                    status_words_due.push_back('{ST_DONE, w.task_id, 1'b1});
                end
            end
            default: ;  // unused code, dropped by the block
        endcase
    endfunction

    // offer one command word, with an occasional gap before it
    task automatic send_word(in_word_t w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        advance_schedule(w);
    endtask

    // receiver: random stall bursts, or one long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // every accepted status word against the oldest one due
    out_word_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (status_words_due.size() == 0) begin
                $display("%0t: unexpected status word, actual %p", $time, m_data);
                mismatches++;
            end else begin
                want = status_words_due.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.fired_id !== want.fired_id) begin
                    $display("%0t: fired_id expected %0d actual %0d",
                             $time, want.fired_id, m_data.fired_id);
                    mismatches++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, want.last, m_data.last);
                    mismatches++;
                end
            end
        end
    end

    // empty list, absent ids, the unused code, duplicates, both period extremes
    task automatic test_basics();
        send_word(make_word(CMD_TICK, 0, 0, 1'b0));
        send_word(make_word(CMD_UNLOAD, 3, 0, 1'b0));
        send_word(make_word(CMD_UNUSED, 15, 16'hffff, 1'b1));
        send_word(make_word(CMD_LOAD, 15, 0, 1'b1));
        send_word(make_word(CMD_LOAD, 0, 16'hffff, 1'b1));
        send_word(make_word(CMD_LOAD, 15, 5, 1'b0));
        send_word(make_word(CMD_LOAD, 7, 1, 1'b0));
        send_word(make_word(CMD_TICK, 0, 0, 1'b0));
        send_word(make_word(CMD_TICK, 0, 0, 1'b0));
    endtask

    // fill all sixteen ids so a tick gives the most fire words, then unload mid-list
    // note: with sixteen ids and room for sixteen, a full refusal cannot occur
    task automatic test_full_walk();
        for (int k = 1; k < 15; k++)
            if (k != 7) send_word(make_word(CMD_LOAD, k, 1, 1'b1));
        send_word(make_word(CMD_TICK, 0, 0, 1'b0));
        send_word(make_word(CMD_UNLOAD, 8, 0, 1'b0));
        send_word(make_word(CMD_TICK, 0, 0, 1'b0));
    endtask

    // receiver holds off while ticks keep coming, so the block backs up
    task automatic test_receiver_hold();
        hold_cycles = 200;
        repeat (20) send_word(make_word(CMD_TICK, 0, 0, 1'b0));
    endtask

    // random mix, mostly meaningful loads and unloads of listed ids
    task automatic test_random_mix(int count);
        int        pick;
        int        id;
        int        per;
        in_word_t  w;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            id   = $urandom_range(0, NUM_IDS - 1);
            per  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(0, 65535);
            if (pick < 40) begin
                w = make_word(CMD_TICK, id, per, $urandom_range(0, 1));
            end else if (pick < 70) begin
                w = make_word(CMD_LOAD, id, per, $urandom_range(0, 3) != 0);
            end else if (pick < 95) begin
                if (lst_len > 0 && $urandom_range(0, 9) < 7)
                    id = lst_ids[$urandom_range(0, lst_len - 1)];
                w = make_word(CMD_UNLOAD, id, per, $urandom_range(0, 1));
            end else begin
                w = make_word(CMD_UNUSED, id, per, $urandom_range(0, 1));
            end
            send_word(w);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basics();
        test_full_walk();
        test_receiver_hold();
        test_random_mix(220);
        calm = 1'b1;
        test_random_mix(45);
        s_valid <= 1'b0;
        while (status_words_due.size() != 0) @(posedge aclk);
        // a dropped or stray word may still be on its way
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/psched_pkg.sv
design/psched_dp.sv
design/psched_ctrl.sv
design/periodic_task_tick_scheduler_top.sv
sim/tb.sv
